[hdl/timed_command_queue_defines.svh]
// ----------------------------------------------------------------------------
// Timed command queue assertion macros
// Shared concurrent assertion wrappers clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_COMMAND_QUEUE_DEFINES_SVH
`define TIMED_COMMAND_QUEUE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define TCQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) expr) \
        else $error(msg);

// expression must never be true out of reset
`define TCQ_NEVER(label, expr, msg) \
    `TCQ_ASSERT(label, !(expr), msg)

`endif

[hdl/tcq_pkg.sv]
// ----------------------------------------------------------------------------
// Timed command queue package
// Opcodes, motion codes and stream field layout shared by the RTL files.
// ----------------------------------------------------------------------------
`default_nettype none

package tcq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    localparam logic [2:0] CODE_FORWARD = 3'd0;
    localparam logic [2:0] CODE_BACK    = 3'd1;
    localparam logic [2:0] CODE_LEFT    = 3'd2;
    localparam logic [2:0] CODE_RIGHT   = 3'd3;
    localparam logic [2:0] CODE_STOP    = 3'd4;

    localparam int CODE_W  = 3;
    localparam int START_W = 48;
    localparam int DUR_W   = 32;
    localparam int EPOCH_W = 48;
    localparam int LOCAL_W = 32;
    localparam int DL_W    = 49;
    localparam int COUNT_W = 4;

    // input tdata layout
    localparam int CODE_LSB  = 0;
    localparam int START_LSB = CODE_LSB + CODE_W;
    localparam int DUR_LSB   = START_LSB + START_W;
    localparam int EPOCH_LSB = DUR_LSB + DUR_W;
    localparam int LOCAL_LSB = EPOCH_LSB + EPOCH_W;
    localparam int S_USED_W  = LOCAL_LSB + LOCAL_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // result tdata layout
    localparam int M_USED_W  = 4 + CODE_W + COUNT_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[hdl/timed_command_queue.sv]
// ----------------------------------------------------------------------------
// Timed command queue: schedule/tick stream in, one status transaction out.
// Input accept to result valid passes the input reg, then the result reg.
// One transaction per cycle unless stalled; queue, deadline update in one pass.
// Reset: aresetn synchronous low clears pointers, count, deadlines, valids.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_command_queue #(
    parameter int QUEUE_DEPTH = tcq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // command_code[2:0], start_ms[50:3], duration_ms[82:51],
    // epoch_now[130:83], local_now[162:131], zero pad
    input  wire logic [tcq_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // schedule_accepted[0], queue_full[1], stop_pulse[2], dispatch_valid[3],
    // dispatch_code[6:4], queue_count[10:7], zero pad
    output logic [tcq_pkg::M_TDATA_W-1:0]     m_tdata
);
    import tcq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 advance;

    logic [CODE_W-1:0]  q_code_reg  [QUEUE_DEPTH];
    logic [START_W-1:0] q_start_reg [QUEUE_DEPTH];
    logic [DUR_W-1:0]   q_dur_reg   [QUEUE_DEPTH];

    logic [IDX_W-1:0] head_reg,  head_next;
    logic [IDX_W-1:0] tail_reg,  tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ep_arm_reg, ep_arm_next;
    logic [DL_W-1:0]  ep_dl_reg,  ep_dl_next;
    logic             lc_arm_reg, lc_arm_next;
    logic [LOCAL_W-1:0] lc_dl_reg, lc_dl_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [CODE_W-1:0]  f_code;
    logic [START_W-1:0] f_start;
    logic [DUR_W-1:0]   f_dur;
    logic [EPOCH_W-1:0] f_enow;
    logic [LOCAL_W-1:0] f_lnow;

    logic [START_W-1:0] h_start;
    logic [DUR_W-1:0]   h_dur;
    logic [CODE_W-1:0]  h_code;
    logic [LOCAL_W-1:0] lc_diff;
    logic               wr_en;
    logic               r_acc, r_full, r_stop, r_dvalid;
    logic [CODE_W-1:0]  r_dcode;
    logic [31:0]        cnt_wide;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign f_code  = in_data_reg[CODE_LSB  +: CODE_W];
    assign f_start = in_data_reg[START_LSB +: START_W];
    assign f_dur   = in_data_reg[DUR_LSB   +: DUR_W];
    assign f_enow  = in_data_reg[EPOCH_LSB +: EPOCH_W];
    assign f_lnow  = in_data_reg[LOCAL_LSB +: LOCAL_W];

    assign h_code  = q_code_reg[head_reg];
    assign h_start = q_start_reg[head_reg];
    assign h_dur   = q_dur_reg[head_reg];
    assign lc_diff = f_lnow - lc_dl_reg;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ep_arm_next = ep_arm_reg;
        ep_dl_next  = ep_dl_reg;
        lc_arm_next = lc_arm_reg;
        lc_dl_next  = lc_dl_reg;
        wr_en       = 1'b0;
        r_acc       = 1'b0;
        r_full      = 1'b0;
        r_stop      = 1'b0;
        r_dvalid    = 1'b0;
        r_dcode     = '0;
        if (in_op_reg == OP_SCHEDULE) begin
            if ((f_start != '0) && (f_code <= CODE_STOP)) begin
                if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                    r_full = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    r_acc      = 1'b1;
                    count_next = count_reg + 1'b1;
                    tail_next  = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : tail_reg + 1'b1;
                end
            end
        end else begin
            if (ep_arm_reg && (f_enow != '0) && ({1'b0, f_enow} >= ep_dl_reg)) begin
                r_stop      = 1'b1;
                ep_arm_next = 1'b0;
                ep_dl_next  = '0;
            end
            if (lc_arm_reg && !lc_diff[LOCAL_W-1]) begin
                r_stop      = 1'b1;
                lc_arm_next = 1'b0;
                lc_dl_next  = '0;
            end
            if ((count_reg != '0) && ((f_enow == '0) || (f_enow >= h_start))) begin
                r_dvalid    = 1'b1;
                r_dcode     = h_code;
                count_next  = count_reg - 1'b1;
                head_next   = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_reg + 1'b1;
                ep_arm_next = 1'b0;
                ep_dl_next  = '0;
                if (h_dur != '0) begin
                    if (f_enow != '0) begin
                        ep_arm_next = 1'b1;
                        ep_dl_next  = {1'b0, h_start} + {{(DL_W-DUR_W){1'b0}}, h_dur};
                    end else begin
                        lc_arm_next = 1'b1;
                        lc_dl_next  = f_lnow + h_dur;
                    end
                end
            end
        end
        cnt_wide = 32'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            ep_arm_reg   <= 1'b0;
            ep_dl_reg    <= '0;
            lc_arm_reg   <= 1'b0;
            lc_dl_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                ep_arm_reg  <= ep_arm_next;
                ep_dl_reg   <= ep_dl_next;
                lc_arm_reg  <= lc_arm_next;
                lc_dl_reg   <= lc_dl_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            m_data_reg <= M_TDATA_W'({cnt_wide[COUNT_W-1:0], r_dcode,
                                      r_dvalid, r_stop, r_full, r_acc});
        end
        if (advance && wr_en) begin
            q_code_reg[tail_reg]  <= f_code;
            q_start_reg[tail_reg] <= f_start;
            q_dur_reg[tail_reg]   <= (f_code == CODE_STOP) ? '0 : f_dur;
        end
    end

endmodule

`default_nettype wire

[hdl/tcq_checker.sv]
// ----------------------------------------------------------------------------
// Timed command queue checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_command_queue_defines.svh"

module tcq_checker #(
    parameter int QUEUE_DEPTH = tcq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tcq_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcq_pkg::*;

    localparam logic [3:0] FULL_COUNT = 4'(QUEUE_DEPTH);

    logic       r_acc, r_full, r_stop, r_dvalid;
    logic [2:0] r_dcode;
    logic [3:0] r_count;
    logic       r_stall, r_sched, r_tick, r_code_ok;

    assign r_acc    = m_tdata[0];
    assign r_full   = m_tdata[1];
    assign r_stop   = m_tdata[2];
    assign r_dvalid = m_tdata[3];
    assign r_dcode  = m_tdata[6:4];
    assign r_count  = m_tdata[10:7];

    assign r_stall   = m_tvalid && !m_tready;
    assign r_sched   = r_acc || r_full;
    assign r_tick    = r_stop || r_dvalid;
    assign r_code_ok = r_dvalid ? (r_dcode <= CODE_STOP) : (r_dcode == '0);

    `TCQ_ASSERT(a_result_held, r_stall |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `TCQ_NEVER(a_sched_tick_mix, m_tvalid && r_sched && r_tick, "mixed schedule and tick flags")
    `TCQ_NEVER(a_acc_and_full, m_tvalid && r_acc && r_full, "accepted and full together")
    `TCQ_ASSERT(a_dispatch_code, m_tvalid |-> r_code_ok, "bad dispatch code")
    `TCQ_ASSERT(a_full_count, m_tvalid && r_full |-> r_count == FULL_COUNT, "full below depth")

endmodule

bind timed_command_queue tcq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tcq_checker (.*);

`default_nettype wire

[dv/timed_command_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed command queue testbench
// Drives schedule and tick transactions with bursty input and a stalling
// output, predicts every status transaction with an in-bench queue and
// deadline tracker, and checks each returned status field by field.
// ----------------------------------------------------------------------------

module timed_command_queue_tb;

    import tcq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 700;

    localparam logic [2:0] CODE_RSVD5 = 3'd5;
    localparam logic [2:0] CODE_RSVD6 = 3'd6;
    localparam logic [2:0] CODE_RSVD7 = 3'd7;

    typedef struct packed {
        logic                op;
        logic [CODE_W-1:0]   code;
        logic [START_W-1:0]  start;
        logic [DUR_W-1:0]    dur;
        logic [EPOCH_W-1:0]  enow;
        logic [LOCAL_W-1:0]  lnow;
    } cmd_item_t;

    typedef struct packed {
        logic                accepted;
        logic                full;
        logic                stop;
        logic                dvalid;
        logic [CODE_W-1:0]   dcode;
        logic [COUNT_W-1:0]  count;
    } queue_status_t;

    class cmd_queue_scoreboard;
        logic [CODE_W-1:0]  slot_code [DEPTH];
        logic [START_W-1:0] slot_start [DEPTH];
        logic [DUR_W-1:0]   slot_dur [DEPTH];
        int                 head;
        int                 tail;
        int                 count;
        logic               epoch_armed;
        logic [DL_W-1:0]    epoch_dl;
        logic               local_armed;
        logic [LOCAL_W-1:0] local_dl;
        queue_status_t      pending_status[$];
        int                 errors;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            epoch_armed = 1'b0;
            epoch_dl = '0;
            local_armed = 1'b0;
            local_dl = '0;
            errors = 0;
        endfunction

        function void predict_item(cmd_item_t it);
            queue_status_t s;
            int h;
            logic [LOCAL_W-1:0] lag;
            s = '0;
            if (it.op == OP_SCHEDULE) begin
                if (it.start != '0 && it.code <= CODE_STOP) begin
                    if (count >= DEPTH) begin
                        s.full = 1'b1;
                    end else begin
                        slot_code[tail]  = it.code;
                        slot_start[tail] = it.start;
                        slot_dur[tail]   = (it.code == CODE_STOP) ? '0 : it.dur;
                        tail = (tail + 1) % DEPTH;
                        count++;
                        s.accepted = 1'b1;
                    end
                end
            end else begin
                if (epoch_armed && it.enow != '0 && {1'b0, it.enow} >= epoch_dl) begin
                    s.stop = 1'b1;
                    epoch_armed = 1'b0;
                    epoch_dl = '0;
                end
                lag = it.lnow - local_dl;
                if (local_armed && !lag[LOCAL_W-1]) begin
                    s.stop = 1'b1;
                    local_armed = 1'b0;
                    local_dl = '0;
                end
                if (count > 0) begin
                    h = head;
                    if (it.enow == '0 || it.enow >= slot_start[h]) begin
                        s.dvalid = 1'b1;
                        s.dcode = slot_code[h];
                        head = (h + 1) % DEPTH;
                        count--;
                        epoch_armed = 1'b0;
                        epoch_dl = '0;
                        if (slot_dur[h] != '0) begin
                            if (it.enow != '0) begin
                                epoch_armed = 1'b1;
                                epoch_dl = {1'b0, slot_start[h]} + DL_W'(slot_dur[h]);
                            end else begin
                                local_armed = 1'b1;
                                local_dl = it.lnow + slot_dur[h];
                            end
                        end
                    end
                end
            end
            s.count = COUNT_W'(count);
            pending_status.push_back(s);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [M_TDATA_W-1:0] word);
            queue_status_t want;
            if (pending_status.size() == 0) begin
                $error("unexpected status transaction: %h", word);
                errors++;
            end else begin
                want = pending_status.pop_front();
                compare_field("schedule_accepted", want.accepted, word[0]);
                compare_field("queue_full", want.full, word[1]);
                compare_field("stop_pulse", want.stop, word[2]);
                compare_field("dispatch_valid", want.dvalid, word[3]);
                compare_field("dispatch_code", want.dcode, word[6:4]);
                compare_field("queue_count", want.count, word[10:7]);
            end
        endfunction

        function int pending();
            return pending_status.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    cmd_queue_scoreboard  sb;
    logic                 hold_req;
    int                   cycle_count;
    logic [EPOCH_W-1:0]   ep_clock;
    logic [LOCAL_W-1:0]   loc_clock;

    timed_command_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed_command_queue_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_status(m_tdata);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic cmd_item_t make_schedule(logic [2:0] code, logic [47:0] start,
                                                logic [31:0] dur);
        cmd_item_t it;
        it.op = OP_SCHEDULE;
        it.code = code;
        it.start = start;
        it.dur = dur;
        it.enow = rand48();
        it.lnow = $urandom;
        return it;
    endfunction

    function automatic cmd_item_t make_tick(logic [47:0] enow, logic [31:0] lnow);
        cmd_item_t it;
        it.op = OP_TICK;
        it.code = 3'($urandom);
        it.start = rand48();
        it.dur = $urandom;
        it.enow = enow;
        it.lnow = lnow;
        return it;
    endfunction

    // mostly coherent schedule/tick traffic around a running clock, some noise
    function automatic cmd_item_t next_random_item();
        cmd_item_t it;
        int pick;
        logic [2:0] code;
        logic [47:0] start;
        logic [31:0] dur;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if ($urandom_range(0, 19) == 0)
                code = 3'($urandom_range(CODE_RSVD5, CODE_RSVD7));
            else
                code = 3'($urandom_range(CODE_FORWARD, CODE_STOP));
            start = ($urandom_range(0, 29) == 0) ? '0 : ep_clock + $urandom_range(0, 200);
            dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
            it = make_schedule(code, start, dur);
        end else if (pick < 92) begin
            ep_clock += $urandom_range(0, 60);
            loc_clock += $urandom_range(0, 60);
            it = make_tick(($urandom_range(0, 4) == 0) ? '0 : ep_clock, loc_clock);
        end else begin
            it = make_tick(rand48(), $urandom);
            it.op = 1'($urandom);
        end
        return it;
    endfunction

    task automatic send(cmd_item_t it);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[CODE_LSB +: CODE_W]   = it.code;
        word[START_LSB +: START_W] = it.start;
        word[DUR_LSB +: DUR_W]     = it.dur;
        word[EPOCH_LSB +: EPOCH_W] = it.enow;
        word[LOCAL_LSB +: LOCAL_W] = it.lnow;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_item(it);
    endtask

    task automatic idle(int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // output side: stretches of full rate, random and mostly ready, plus one long hold
    initial begin
        int mode;
        int len;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(5, 40);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        int burst_left;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        hold_req = 1'b0;
        cycle_count = 0;
        ep_clock = rand48();
        loc_clock = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // epoch deadline, stop with duration ignored
        send(make_tick('0, '0));
        send(make_schedule(CODE_FORWARD, 48'd1000, 32'd100));
        send(make_schedule(CODE_STOP, 48'd1010, 32'd555));
        send(make_tick(48'd999, 32'd0));
        send(make_tick(48'd1000, 32'd1));
        send(make_tick(48'd1100, 32'd2));
        // no valid time: local deadline across the wrap
        send(make_schedule(CODE_BACK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send(make_tick('0, 32'hFFFF_FFF0));
        send(make_tick('0, 32'hFFFF_FFEE));
        send(make_tick('0, 32'hFFFF_FFEF));
        // dispatch late at max epoch, deadline of 15 fires at tick 15, not at tick 14
        send(make_schedule(CODE_LEFT, 48'd5, 32'd10));
        send(make_tick(48'hFFFF_FFFF_FFFF, 32'd0));
        send(make_tick(48'd14, 32'd0));
        send(make_tick(48'd15, 32'd0));
        // rejects
        send(make_schedule(CODE_FORWARD, '0, 32'd7));
        send(make_schedule(CODE_RSVD5, 48'd1, 32'd1));
        send(make_schedule(CODE_RSVD6, 48'd1, 32'd1));
        send(make_schedule(CODE_RSVD7, 48'd1, 32'd1));
        // fill to full and one more
        repeat (DEPTH + 1) send(make_schedule(CODE_RIGHT, 48'd1, 32'd1));
        drain();

        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 200) begin
                hold_req = 1'b1;
                burst_left = 80;
            end
            if (i == 400) drain();
            if (burst_left == 0) begin
                idle($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
            send(next_random_item());
            burst_left--;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("timed_command_queue_tb: done, clean");
        else
            $display("timed_command_queue_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/tcq_pkg.sv
hdl/timed_command_queue.sv
hdl/tcq_checker.sv
dv/timed_command_queue_tb.sv
